[rtl/prg_pkg.sv]
// Package for the primary ray generator: field widths, register indexes and
// the structs that travel beside the data through the root and divide pipes.
// No dependencies.
package prg_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;
  localparam int LANE_W    = 16;
  localparam int COORD_W   = 11;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 96;
  localparam int UV_W      = 14;
  localparam int D_W       = 40;
  localparam int A_W       = 30;
  localparam int NORM_MSB  = 29;
  localparam int SQ_W      = 60;
  localparam int S_W       = 62;
  localparam int R_W       = 31;

  localparam logic [CFG_IDX_W-1:0] REG_BASIS_U = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_N = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EYE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_XMIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_YMIN    = 3'd6;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } prg_flags_t;

  typedef struct packed {
    logic [2:0][A_W-1:0] mag;
    prg_flags_t          flags;
  } prg_norm_t;

endpackage

[rtl/prg_isqrt.sv]
// Pipelined integer square root, one result bit per stage, 32 stages.
// Depends on prg_pkg; carries the normalized magnitudes and flags alongside.
module prg_isqrt import prg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [S_W-1:0]   s_in,
  input  prg_norm_t        sb_in,
  output logic             out_valid,
  output logic [R_W-1:0]   root,
  output prg_norm_t        sb_out
);

  localparam int STAGES = 32;

  logic             vld [STAGES];
  logic [63:0]      rem [STAGES];
  logic [63:0]      res [STAGES];
  prg_norm_t        sb  [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (2 * (STAGES - 1 - j));
    logic [63:0] rem_i;
    logic [63:0] res_i;
    logic [63:0] trial;
    logic        v_i;
    prg_norm_t   sb_i;

    if (j == 0) begin : g_first
      assign rem_i = {2'b00, s_in};
      assign res_i = 64'd0;
      assign v_i   = in_valid;
      assign sb_i  = sb_in;
    end else begin : g_next
      assign rem_i = rem[j-1];
      assign res_i = res[j-1];
      assign v_i   = vld[j-1];
      assign sb_i  = sb[j-1];
    end

    assign trial = res_i + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb[j] <= sb_i;
        if (rem_i >= trial) begin
          rem[j] <= rem_i - trial;
          res[j] <= (res_i >> 1) + BIT;
        end else begin
          rem[j] <= rem_i;
          res[j] <= res_i >> 1;
        end
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign root      = res[STAGES-1][R_W-1:0];
  assign sb_out    = sb[STAGES-1];

endmodule

[rtl/prg_divide.sv]
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage. Depends on prg_pkg for the flag struct.
module prg_divide import prg_pkg::*; #(
  parameter int FRAC = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2:0][R_W+FRAC-1:0]      num,
  input  logic [R_W-1:0]                den,
  input  prg_flags_t                    sb_in,
  output logic                          out_valid,
  output logic [2:0][FRAC:0]            quo,
  output prg_flags_t                    sb_out
);

  localparam int NW = R_W + FRAC;
  localparam int QB = FRAC + 1;

  logic                  vld [QB];
  logic [2:0][NW-1:0]    rem [QB];
  logic [2:0][QB-1:0]    qq  [QB];
  logic [R_W-1:0]        dv  [QB];
  prg_flags_t            sb  [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int SH = QB - 1 - j;
    logic [2:0][NW-1:0] rem_i;
    logic [2:0][QB-1:0] q_i;
    logic [R_W-1:0]     d_i;
    logic               v_i;
    prg_flags_t         sb_i;
    logic [NW-1:0]      dsh;

    if (j == 0) begin : g_first
      assign rem_i = num;
      assign q_i   = '0;
      assign d_i   = den;
      assign v_i   = in_valid;
      assign sb_i  = sb_in;
    end else begin : g_next
      assign rem_i = rem[j-1];
      assign q_i   = qq[j-1];
      assign d_i   = dv[j-1];
      assign v_i   = vld[j-1];
      assign sb_i  = sb[j-1];
    end

    assign dsh = NW'(d_i) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j] <= d_i;
        sb[j] <= sb_i;
        for (int k = 0; k < 3; k++) begin
          if (rem_i[k] >= dsh) begin
            rem[j][k] <= rem_i[k] - dsh;
            qq[j][k]  <= {q_i[k][QB-2:0], 1'b1};
          end else begin
            rem[j][k] <= rem_i[k];
            qq[j][k]  <= {q_i[k][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = vld[QB-1];
  assign quo       = qq[QB-1];
  assign sb_out    = sb[QB-1];

endmodule

[rtl/primary_ray_generation.sv]
// Pinhole camera primary ray generator, one ray per clock when the output flows.
// The pipe holds eight front stages, 32 square root stages, one numerator stage,
// DIR_FRAC_BITS + 1 divide stages and the output register. The whole pipe
// advances together when the output word is empty or taken. Synchronous reset
// empties the pipe and restores the camera registers to their reset values
// (distance 1.0, all else zero).
module primary_ray_generation import prg_pkg::*; #(
  parameter int PIXEL_BITS    = 11,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,   // pixel_col, pixel_row
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  output logic                 m_axis_tuser,   // zero_direction
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NW = R_W + DIR_FRAC_BITS;
  localparam logic [COORD_W-1:0] PMASK = (PIXEL_BITS >= COORD_W) ?
      {COORD_W{1'b1}} : COORD_W'((1 << PIXEL_BITS) - 1);

  // Camera registers.
  logic [CFG_W-1:0]  basis_u, basis_v, basis_n, eye_point;
  logic [15:0]       view_distance;
  logic [11:0]       x_min, y_min;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_u       <= '0;
      basis_v       <= '0;
      basis_n       <= '0;
      eye_point     <= '0;
      view_distance <= 16'd256;
      x_min         <= '0;
      y_min         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASIS_U: basis_u       <= cfg_data;
        REG_BASIS_V: basis_v       <= cfg_data;
        REG_BASIS_N: basis_n       <= cfg_data;
        REG_EYE:     eye_point     <= cfg_data;
        REG_DIST:    view_distance <= cfg_data[15:0];
        REG_XMIN:    x_min         <= cfg_data[11:0];
        REG_YMIN:    y_min         <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid;
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: half-pixel center coordinates.
  logic                   s1_v;
  logic signed [UV_W-1:0] s1_u2, s1_v2;
  logic [COORD_W-1:0]     col_m, row_m;
  assign col_m = s_axis_tdata[COORD_W-1:0] & PMASK;
  assign row_m = s_axis_tdata[2*COORD_W-1:COORD_W] & PMASK;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u2 <= ((UV_W'($signed(x_min)) + $signed(UV_W'(col_m))) <<< 1) + UV_W'(1);
      s1_v2 <= ((UV_W'($signed(y_min)) + $signed(UV_W'(row_m))) <<< 1) + UV_W'(1);
    end
  end

  // Stage 2: the nine products.
  logic               s2_v;
  logic signed [32:0] s2_pn [3];
  logic signed [29:0] s2_pu [3];
  logic signed [29:0] s2_pv [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_pn[k] <= $signed({1'b0, view_distance}) * $signed(basis_n[16*k +: 16]);
        s2_pu[k] <= s1_u2 * $signed(basis_u[16*k +: 16]);
        s2_pv[k] <= s1_v2 * $signed(basis_v[16*k +: 16]);
      end
    end
  end

  // Stage 3: direction components in units of 2^-22, split into sign and size.
  logic               s3_v;
  logic [D_W-1:0]     s3_mag [3];
  logic [2:0]         s3_neg;
  logic signed [D_W-1:0] d_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_c[k] = ((D_W'(s2_pu[k]) + D_W'(s2_pv[k])) <<< 7) - D_W'(s2_pn[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_neg[k] <= d_c[k][D_W-1];
        s3_mag[k] <= d_c[k][D_W-1] ? D_W'(-d_c[k]) : D_W'(d_c[k]);
      end
    end
  end

  // Stage 4: the leading one of the OR of the sizes is that of the largest;
  // first find its byte.
  logic           s4_v;
  logic [D_W-1:0] s4_mag [3];
  logic [2:0]     s4_neg;
  logic           s4_zero;
  logic [2:0]     s4_cidx;
  logic [7:0]     s4_chunk;
  logic [D_W-1:0] orv;
  logic [2:0]     cidx_c;
  logic [7:0]     chunk_c;

  always_comb begin
    orv     = s3_mag[0] | s3_mag[1] | s3_mag[2];
    cidx_c  = 3'd0;
    chunk_c = orv[7:0];
    for (int b = 1; b < D_W / 8; b++) begin
      if (orv[8*b +: 8] != 8'd0) begin
        cidx_c  = 3'(b);
        chunk_c = orv[8*b +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mag   <= s3_mag;
      s4_neg   <= s3_neg;
      s4_zero  <= (orv == '0);
      s4_cidx  <= cidx_c;
      s4_chunk <= chunk_c;
    end
  end

  // Stage 5: leading bit inside that byte.
  logic           s5_v;
  logic [D_W-1:0] s5_mag [3];
  logic [2:0]     s5_neg;
  logic           s5_zero;
  logic [5:0]     s5_top;
  logic [2:0]     pos_c;

  always_comb begin
    pos_c = 3'd0;
    for (int b = 1; b < 8; b++) begin
      if (s4_chunk[b]) pos_c = 3'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_mag  <= s4_mag;
      s5_neg  <= s4_neg;
      s5_zero <= s4_zero;
      s5_top  <= {s4_cidx, pos_c};
    end
  end

  // Stage 6: one common shift puts the largest size in [2^29, 2^30).
  logic       s6_v;
  prg_norm_t  s6_norm;
  logic [D_W+NORM_MSB-1:0] wide_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wide_c[k] = {s5_mag[k], {NORM_MSB{1'b0}}} >> s5_top;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) s6_norm.mag[k] <= wide_c[k][A_W-1:0];
      s6_norm.flags.neg  <= s5_neg;
      s6_norm.flags.zero <= s5_zero;
    end
  end

  // Stage 7: squares. Stage 8: their sum.
  logic            s7_v, s8_v;
  logic [SQ_W-1:0] s7_sq [3];
  prg_norm_t       s7_norm, s8_norm;
  logic [S_W-1:0]  s8_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) s7_sq[k] <= s6_norm.mag[k] * s6_norm.mag[k];
      s7_norm <= s6_norm;
      s8_sum  <= S_W'(s7_sq[0]) + S_W'(s7_sq[1]) + S_W'(s7_sq[2]);
      s8_norm <= s7_norm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
      s8_v <= 1'b0;
    end else if (adv) begin
      s1_v <= s_axis_tvalid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
      s8_v <= s7_v;
    end
  end

  logic           sq_v;
  logic [R_W-1:0] sq_root;
  prg_norm_t      sq_norm;

  prg_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s8_v),
    .s_in      (s8_sum),
    .sb_in     (s8_norm),
    .out_valid (sq_v),
    .root      (sq_root),
    .sb_out    (sq_norm)
  );

  // Numerators with the half-divisor rounding term.
  logic                  nm_v;
  logic [2:0][NW-1:0]    nm_num;
  logic [R_W-1:0]        nm_den;
  prg_flags_t            nm_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_v <= 1'b0;
    end else if (adv) begin
      nm_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        nm_num[k] <= (NW'(sq_norm.mag[k]) << DIR_FRAC_BITS) + NW'(sq_root >> 1);
      end
      nm_den   <= sq_root;
      nm_flags <= sq_norm.flags;
    end
  end

  logic                      dv_v;
  logic [2:0][DIR_FRAC_BITS:0] dv_q;
  prg_flags_t                dv_flags;

  prg_divide #(.FRAC(DIR_FRAC_BITS)) u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (nm_v),
    .num       (nm_num),
    .den       (nm_den),
    .sb_in     (nm_flags),
    .out_valid (dv_v),
    .quo       (dv_q),
    .sb_out    (dv_flags)
  );

  // Output word: sign, saturation and the zero case.
  logic [2:0][LANE_W-1:0] dir_c;
  logic [31:0]            qx;
  logic [47:0]            out_dir;
  logic [47:0]            out_origin;
  logic                   out_zero;

  always_comb begin
    qx = '0;
    for (int k = 0; k < 3; k++) begin
      qx = 32'(dv_q[k]);
      if (dv_flags.zero) begin
        dir_c[k] = '0;
      end else if (dv_flags.neg[k]) begin
        dir_c[k] = (qx > 32'd32768) ? 16'h8000 : LANE_W'(~qx + 32'd1);
      end else begin
        dir_c[k] = (qx > 32'd32767) ? 16'h7FFF : qx[LANE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dir    <= dir_c;
      out_origin <= eye_point;
      out_zero   <= dv_flags.zero;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_dir, out_origin};
  assign m_axis_tuser  = out_zero;

endmodule

[rtl/prg_checker.sv]
// Port-level checks for the primary ray generator, bound to the top level.
// Depends on prg_pkg for port widths.
module prg_checker import prg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [IN_W-1:0]      s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_W-1:0]     m_axis_tdata,
  input logic                 m_axis_tuser
);

  // A waiting result word holds still.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // A degenerate ray carries an all-zero direction.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[95:48] == 48'd0)
    else $error("zero direction flag with nonzero direction");

  // A normalized ray always has some nonzero component.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:48] != 48'd0)
    else $error("unit direction came out zero");

  // Reset empties the output.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word valid after reset");

  // With no result waiting the pipe always takes a new word.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");

endmodule

bind primary_ray_generation prg_checker u_prg_checker (.*);

[sim/primary_ray_generation_tb.sv]
// Testbench for primary_ray_generation: drives pixel words, writes the camera
// registers between phases and checks every ray against an in-bench predictor.
// Depends on prg_pkg and the primary_ray_generation RTL.
module primary_ray_generation_tb;
  import prg_pkg::*;

  localparam int PIX_W  = 11;
  localparam int FRAC_W = 14;
  localparam int LATENCY = FRAC_W + 43;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic        zero_dir;
    logic [15:0] dir_z, dir_y, dir_x, org_z, org_y, org_x;
  } ray_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Camera state as the predictor sees it.
  logic [47:0] cam_u, cam_v, cam_n, cam_eye;
  logic [15:0] cam_dist;
  logic [11:0] cam_xmin, cam_ymin;

  ray_t expected_rays[$];
  int   errors = 0;
  bit   hold_off = 0;

  always #4 clk = ~clk;

  primary_ray_generation u_top (.*);

  function automatic longint lane_of(logic [47:0] r, int k);
    return longint'($signed(r[16*k +: 16]));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= res + bit_v) begin
        s -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic ray_t trace_ray(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    ray_t r;
    longint u2, v2, d;
    longint unsigned mag[3], m, s, rt, q;
    bit neg[3];
    int top;
    u2 = 2 * (longint'($signed(cam_xmin)) + longint'(col)) + 1;
    v2 = 2 * (longint'($signed(cam_ymin)) + longint'(row)) + 1;
    m = 0;
    for (int k = 0; k < 3; k++) begin
      d = -longint'(cam_dist) * lane_of(cam_n, k)
          + (u2 * lane_of(cam_u, k) + v2 * lane_of(cam_v, k)) * 128;
      neg[k] = d < 0;
      mag[k] = neg[k] ? longint'(-d) : d;
      if (mag[k] > m) m = mag[k];
    end
    r.org_x = cam_eye[15:0];
    r.org_y = cam_eye[31:16];
    r.org_z = cam_eye[47:32];
    if (m == 0) begin
      r.dir_x = '0; r.dir_y = '0; r.dir_z = '0; r.zero_dir = 1'b1;
      return r;
    end
    top = 63;
    while (m[top] == 0) top--;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      if (top > 29) mag[k] >>= (top - 29);
      else mag[k] <<= (29 - top);
      s += mag[k] * mag[k];
    end
    rt = int_sqrt(s);
    for (int k = 0; k < 3; k++) begin
      logic [15:0] c;
      q = ((mag[k] << FRAC_W) + (rt >> 1)) / rt;
      if (neg[k]) c = (q > 32768) ? 16'h8000 : 16'(-longint'(q));
      else c = (q > 32767) ? 16'h7fff : 16'(q);
      case (k)
        0: r.dir_x = c;
        1: r.dir_y = c;
        default: r.dir_z = c;
      endcase
    end
    r.zero_dir = 1'b0;
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // The word stays offered after acceptance until the next call or a drain,
  // so back to back words never get two assignments in one step.
  task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      idle_cycles(gap);
    end
    s_axis_tdata <= {2'b00, row, col};
    s_axis_tvalid <= 1;
    expected_rays.push_back(trace_ray(col, row));
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_BASIS_U: cam_u = val;
      REG_BASIS_V: cam_v = val;
      REG_BASIS_N: cam_n = val;
      REG_EYE:     cam_eye = val;
      REG_DIST:    cam_dist = val[15:0];
      REG_XMIN:    cam_xmin = val[11:0];
      REG_YMIN:    cam_ymin = val[11:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (expected_rays.size() != 0) @(negedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Q2.14 lanes drawn mostly within [-1.0, 1.0], sometimes anywhere.
  function automatic logic [47:0] rand_basis();
    logic [47:0] b;
    for (int k = 0; k < 3; k++)
      b[16*k +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                      : 16'($signed($urandom_range(0, 32768)) - 16384);
    return b;
  endfunction

  task automatic test_reset_camera;
    // Reset basis is all zero, so every ray is degenerate.
    send_pixel(11'd0, 11'd0);
    send_pixel(11'h7ff, 11'h7ff);
    drain();
  endtask

  task automatic test_directed;
    write_reg(REG_BASIS_U, {16'h0000, 16'h0000, 16'h4000});
    write_reg(REG_BASIS_V, {16'h0000, 16'h4000, 16'h0000});
    write_reg(REG_BASIS_N, {16'h4000, 16'h0000, 16'h0000});
    write_reg(REG_EYE, {16'h8000, 16'h7fff, 16'h0100});
    write_reg(REG_DIST, CFG_W'(16'h0100));
    write_reg(REG_XMIN, CFG_W'(12'h800));
    write_reg(REG_YMIN, CFG_W'(12'h7ff));
    send_pixel(11'd0, 11'd0);
    send_pixel(11'h7ff, 11'd0);
    send_pixel(11'd0, 11'h7ff);
    send_pixel(11'h7ff, 11'h7ff);
    send_pixel(11'h555, 11'h2aa);
    drain();
    // Image plane passes through the eye and the pixel centers cancel: a
    // zero-length direction.
    write_reg(REG_DIST, CFG_W'(16'h0000));
    write_reg(REG_XMIN, CFG_W'(12'hfff));
    write_reg(REG_YMIN, CFG_W'(12'hfff));
    write_reg(REG_BASIS_U, {16'h0000, 16'h0000, 16'h4000});
    write_reg(REG_BASIS_V, {16'h0000, 16'h0000, 16'hc000});
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd1, 11'd1);
    drain();
    // Largest magnitudes everywhere.
    write_reg(REG_BASIS_U, {3{16'h8000}});
    write_reg(REG_BASIS_V, {3{16'h7fff}});
    write_reg(REG_BASIS_N, {16'h8000, 16'h7fff, 16'h8000});
    write_reg(REG_DIST, CFG_W'(16'hffff));
    write_reg(REG_XMIN, CFG_W'(12'h7ff));
    write_reg(REG_YMIN, CFG_W'(12'h800));
    send_pixel(11'h7ff, 11'd0);
    send_pixel(11'd0, 11'h7ff);
    send_pixel(11'h400, 11'h400);
    drain();
    // An unknown index changes nothing.
    write_reg(REG_NONE, rand48());
    send_pixel(11'd3, 11'd5);
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(REG_BASIS_U, rand_basis());
      write_reg(REG_BASIS_V, rand_basis());
      write_reg(REG_BASIS_N, rand_basis());
      write_reg(REG_EYE, rand48());
      write_reg(REG_DIST, CFG_W'(($urandom_range(0, 1)) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 1024))));
      write_reg(REG_XMIN, CFG_W'(12'($urandom)));
      write_reg(REG_YMIN, CFG_W'(12'($urandom)));
      for (int i = 0; i < per_phase; i++)
        send_pixel(11'($urandom), 11'($urandom), (p % 3) != 0);
      drain();
    end
  endtask

  task automatic test_backpressure;
    hold_off = 1;
    for (int i = 0; i < 80; i++) send_pixel(11'($urandom), 11'($urandom), 0);
    drain();
  endtask

  // Receiver: holds ready low for a random wait, possibly none, before each word,
  // or for one long hold-off when asked, then takes the next word.
  initial begin
    int wait_n;
    @(negedge clk);
    forever begin
      wait_n = $urandom_range(0, 7);
      if (hold_off) begin
        wait_n = 200;
        hold_off = 0;
      end
      if (wait_n != 0) begin
        m_axis_tready <= 0;
        repeat (wait_n) @(negedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      ray_t got, exp_ray;
      got = {m_axis_tuser, m_axis_tdata};
      if (expected_rays.size() == 0) begin
        $error("unexpected ray %h", got);
        errors++;
      end else begin
        exp_ray = expected_rays.pop_front();
        if (got.org_x !== exp_ray.org_x) begin
          $error("origin_x exp %h got %h", exp_ray.org_x, got.org_x); errors++; end
        if (got.org_y !== exp_ray.org_y) begin
          $error("origin_y exp %h got %h", exp_ray.org_y, got.org_y); errors++; end
        if (got.org_z !== exp_ray.org_z) begin
          $error("origin_z exp %h got %h", exp_ray.org_z, got.org_z); errors++; end
        if (got.dir_x !== exp_ray.dir_x) begin
          $error("dir_x exp %h got %h", exp_ray.dir_x, got.dir_x); errors++; end
        if (got.dir_y !== exp_ray.dir_y) begin
          $error("dir_y exp %h got %h", exp_ray.dir_y, got.dir_y); errors++; end
        if (got.dir_z !== exp_ray.dir_z) begin
          $error("dir_z exp %h got %h", exp_ray.dir_z, got.dir_z); errors++; end
        if (got.zero_dir !== exp_ray.zero_dir) begin
          $error("zero_direction exp %b got %b", exp_ray.zero_dir, got.zero_dir);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("primary_ray_generation: mismatch");
    $finish;
  end

  initial begin
    cam_u = 0; cam_v = 0; cam_n = 0; cam_eye = 0;
    cam_dist = 16'd256; cam_xmin = 0; cam_ymin = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_reset_camera();
    test_directed();
    test_backpressure();
    test_random(20, 30);
    idle_cycles(LATENCY + 10);
    if (errors == 0 && expected_rays.size() == 0)
      $display("primary_ray_generation: match");
    else
      $display("primary_ray_generation: mismatch");
    $finish;
  end
endmodule
